/* src/ata_pkg.sv */
// Shared constants, the pipeline vector type and the arctangent step table
// for the accelerometer tilt angle block. Depends on nothing.
`default_nettype none

package ata_pkg;

  // Default width of one acceleration sample.
  localparam int unsigned SampleBitsDef = 16;
  // Width of each angle on the result channel.
  localparam int unsigned AngleW = 16;
  // Width of the rotating vector and of the binary angle accumulator.
  localparam int unsigned CordicW = 46;
  localparam int unsigned AngW = 34;
  // Number of rotation steps.
  localparam int unsigned CordicSteps = 28;
  // Vectors are normalised so that the larger magnitude ends up in [2^40, 2^41).
  localparam int unsigned NormTop = 41;
  // Normalisation uses conditional shifts of 32, 16, 8, 4, 2 and 1.
  localparam int unsigned NormStages = 6;
  // Lane latency: set-up, normalisation, rotations, magnitude, scale, round.
  localparam int unsigned LaneLat = 1 + NormStages + CordicSteps + 3;
  // Half a turn in binary angle units (2^32 is a full turn).
  localparam logic signed [AngW-1:0] HalfTurn = 34'sh0_8000_0000;
  // Hundredths of a degree in a full turn, and the largest magnitude.
  localparam logic [15:0] ScaleCdeg = 16'd36000;
  localparam logic [16:0] MaxCdeg = 17'd18000;

  // Vector that travels from cell to cell along an arctangent lane.
  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AngW-1:0]    ang;
    logic                      skip;  // y was zero: the angle is only the base
  } vec_t;

  // atan(2^-i) in binary angle units, rounded.
  function automatic logic [31:0] atan_step(input int unsigned i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      24: t = 32'h00000029;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

/* src/ata_sqrt_cell.sv */
// One digit cell of the pipelined integer square root.
// Depends on nothing; chained by the top level, one cell per root bit.
`default_nettype none

module ata_sqrt_cell #(
  parameter int unsigned OpW    = 49,
  parameter int unsigned BitPos = 0
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [OpW-1:0] op_i,
  input  wire logic [OpW-1:0] res_i,
  output logic      [OpW-1:0] op_o,
  output logic      [OpW-1:0] res_o
);

  localparam logic [OpW-1:0] BitVal = {{(OpW-1){1'b0}}, 1'b1} << (2 * BitPos);

  logic [OpW-1:0] trial;
  logic [OpW-1:0] op_d, op_q;
  logic [OpW-1:0] res_d, res_q;

  // Try to take this digit; keep the remainder when it fits.
  always_comb begin
    trial = res_i + BitVal;
    if (op_i >= trial) begin
      op_d  = op_i - trial;
      res_d = (res_i >> 1) + BitVal;
    end else begin
      op_d  = op_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q  <= op_d;
      res_q <= res_d;
    end
  end

  assign op_o  = op_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

/* src/ata_cordic_cell.sv */
// One vectoring rotation cell of an arctangent lane.
// Depends on ata_pkg for the vector type and the step angle table.
`default_nettype none

module ata_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire ata_pkg::vec_t vec_i,
  output ata_pkg::vec_t      vec_o
);

  localparam logic signed [ata_pkg::AngW-1:0] StepAng =
    $signed({2'b00, ata_pkg::atan_step(Step)});

  logic signed [ata_pkg::CordicW-1:0] dx, dy;
  ata_pkg::vec_t vec_d, vec_q;

  // Turn the vector towards the x axis and book the angle turned.
  always_comb begin
    dx    = vec_i.y >>> Step;
    dy    = vec_i.x >>> Step;
    vec_d = vec_i;
    if (!vec_i.skip) begin
      if (vec_i.y > 0) begin
        vec_d.x   = vec_i.x + dx;
        vec_d.y   = vec_i.y - dy;
        vec_d.ang = vec_i.ang + StepAng;
      end else begin
        vec_d.x   = vec_i.x - dx;
        vec_d.y   = vec_i.y + dy;
        vec_d.ang = vec_i.ang - StepAng;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

/* src/ata_atan2_lane.sv */
// Pipelined four-quadrant arctangent lane giving hundredths of a degree.
// Depends on ata_pkg and ata_cordic_cell.
`default_nettype none

module ata_atan2_lane (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [ata_pkg::CordicW-1:0] x_i,
  input  wire logic signed [ata_pkg::CordicW-1:0] y_i,
  output logic signed [ata_pkg::AngleW-1:0]       angle_o
);

  localparam int unsigned CW = ata_pkg::CordicW;
  localparam int unsigned AW = ata_pkg::AngW;

  ata_pkg::vec_t  a_d;
  logic [CW-1:0]  ax, ay;
  ata_pkg::vec_t  nv_q [ata_pkg::NormStages+1];
  logic [CW-1:0]  nm_q [ata_pkg::NormStages+1];
  ata_pkg::vec_t  cv   [ata_pkg::CordicSteps+1];

  // Set-up: turn a left half-plane vector by half a turn.
  always_comb begin
    ax       = x_i[CW-1] ? CW'(-x_i) : CW'(x_i);
    ay       = y_i[CW-1] ? CW'(-y_i) : CW'(y_i);
    a_d.skip = (y_i == '0);
    if (x_i[CW-1]) begin
      a_d.x   = -x_i;
      a_d.y   = -y_i;
      a_d.ang = y_i[CW-1] ? -ata_pkg::HalfTurn : ata_pkg::HalfTurn;
    end else begin
      a_d.x   = x_i;
      a_d.y   = y_i;
      a_d.ang = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nv_q[0] <= a_d;
      nm_q[0] <= ax | ay;
    end
  end

  // Normalisation: binary search of the left shift, one power of two a stage.
  for (genvar j = 0; j < ata_pkg::NormStages; j++) begin : g_norm
    localparam int unsigned Sh = 32 >> j;
    logic fits;
    ata_pkg::vec_t sh_v;
    assign fits = ((nm_q[j] >> (ata_pkg::NormTop - Sh)) == '0);
    always_comb begin
      sh_v = nv_q[j];
      if (fits) begin
        sh_v.x = nv_q[j].x <<< Sh;
        sh_v.y = nv_q[j].y <<< Sh;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nv_q[j+1] <= sh_v;
        nm_q[j+1] <= fits ? (nm_q[j] << Sh) : nm_q[j];
      end
    end
  end

  // Row of rotation cells.
  assign cv[0] = nv_q[ata_pkg::NormStages];
  for (genvar k = 0; k < ata_pkg::CordicSteps; k++) begin : g_rot
    ata_cordic_cell #(.Step(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .vec_i (cv[k]),
      .vec_o (cv[k+1])
    );
  end

  // Conversion from binary angle units to hundredths of a degree.
  logic signed [AW-1:0] fin_ang;
  logic [AW-2:0]        mag_q;
  logic                 neg1_q, neg2_q;
  logic [AW+14:0]       prod_q;
  logic [AW+14:0]       rnd;
  logic [16:0]          q_abs;
  logic signed [ata_pkg::AngleW-1:0] angle_d, angle_q;

  assign fin_ang = cv[ata_pkg::CordicSteps].ang;

  always_comb begin
    rnd   = prod_q + (AW+15)'(64'h8000_0000);
    q_abs = rnd[AW+14:32];
    if (q_abs > ata_pkg::MaxCdeg) begin
      q_abs = ata_pkg::MaxCdeg;
    end
    angle_d = neg2_q ? -$signed(q_abs[15:0]) : $signed(q_abs[15:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= fin_ang[AW-1] ? (AW-1)'(-fin_ang) : (AW-1)'(fin_ang);
      neg1_q  <= fin_ang[AW-1];
      prod_q  <= mag_q * ata_pkg::ScaleCdeg;
      neg2_q  <= neg1_q;
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

/* src/accel_tilt_angles.sv */
// Top level of the accelerometer tilt angle block: squares, root and three lanes.
// Depends on ata_pkg, ata_sqrt_cell and ata_atan2_lane.
`default_nettype none

// One sample (x, y, z) in, pitch, roll and yaw in hundredths of a degree out.
// The block is a single stall-together pipeline that accepts one sample in
// every cycle while it is not held; each sample passes the input register,
// the squares and their sum, one register per bit of the square root, then
// the arctangent lanes, which hold 28 rotation cells each. When the result
// register is full and not taken, the whole pipeline holds and tready falls
// with it.

module accel_tilt_angles #(
  parameter int unsigned SAMPLE_BITS = ata_pkg::SampleBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // acc_x, acc_y, acc_z from the lowest bit up, zero padded to bytes
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // pitch_cdeg, roll_cdeg, yaw_cdeg from the lowest bit up
  output logic [((3*ata_pkg::AngleW+7)/8)*8-1:0]  m_axis_tdata
);

  localparam int unsigned S       = SAMPLE_BITS;
  localparam int unsigned RootW   = S + 8;
  localparam int unsigned OpW     = 2 * RootW + 1;
  localparam int unsigned CW      = ata_pkg::CordicW;
  localparam int unsigned AngleW  = ata_pkg::AngleW;
  localparam int unsigned OutW    = ((3*AngleW+7)/8)*8;
  localparam int unsigned Latency = 3 + RootW + ata_pkg::LaneLat;
  localparam logic signed [S-1:0] MinS = {1'b1, {(S-1){1'b0}}};
  localparam logic signed [S-1:0] MaxS = {1'b0, {(S-1){1'b1}}};

  logic en;
  logic [Latency-1:0] vld_q;

  // The whole pipeline moves unless a finished result waits.
  assign en            = !vld_q[Latency-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], s_axis_tvalid};
    end
  end

  // Input, squares and the scaled sum of squares.
  logic signed [S-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
  logic [2*S-1:0]      xx_q, zz_q;
  logic [OpW-1:0]      op_q;
  logic signed [S-1:0] dly_x_q [RootW+1];
  logic signed [S-1:0] dly_y_q [RootW+1];
  logic signed [S-1:0] dly_z_q [RootW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q       <= $signed(s_axis_tdata[S-1:0]);
      y0_q       <= $signed(s_axis_tdata[2*S-1:S]);
      z0_q       <= $signed(s_axis_tdata[3*S-1:2*S]);
      xx_q       <= $unsigned((2*S)'(x0_q) * (2*S)'(x0_q));
      zz_q       <= $unsigned((2*S)'(z0_q) * (2*S)'(z0_q));
      x1_q       <= x0_q;
      y1_q       <= y0_q;
      z1_q       <= z0_q;
      op_q       <= (OpW'(xx_q) + OpW'(zz_q)) << 16;
      dly_x_q[0] <= x1_q;
      dly_y_q[0] <= y1_q;
      dly_z_q[0] <= z1_q;
    end
  end

  // Square root cells, with the sample carried alongside.
  logic [OpW-1:0] sop [RootW+1];
  logic [OpW-1:0] sres [RootW+1];

  assign sop[0]  = op_q;
  assign sres[0] = '0;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    ata_sqrt_cell #(.OpW(OpW), .BitPos(RootW - 1 - k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .op_i  (sop[k]),
      .res_i (sres[k]),
      .op_o  (sop[k+1]),
      .res_o (sres[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        dly_x_q[k+1] <= dly_x_q[k];
        dly_y_q[k+1] <= dly_y_q[k];
        dly_z_q[k+1] <= dly_z_q[k];
      end
    end
  end

  // Lane arguments.
  logic [RootW-1:0]     root;
  logic signed [S-1:0]  sx, sy, sz, negx;
  logic signed [CW-1:0] p_x, p_y, r_x, r_y, w_x, w_y;

  always_comb begin
    root = sres[RootW][RootW-1:0];
    sx   = dly_x_q[RootW];
    sy   = dly_y_q[RootW];
    sz   = dly_z_q[RootW];
    negx = (sx == MinS) ? MaxS : -sx;
    p_x  = $signed({{(CW-RootW){1'b0}}, root});
    p_y  = CW'(sy) <<< 8;
    r_x  = CW'(sz);
    r_y  = CW'(negx);
    w_x  = CW'(sx);
    w_y  = CW'(sy);
  end

  logic signed [AngleW-1:0] pitch, roll, yaw;

  ata_atan2_lane u_pitch (.clk_i(clk_i), .en_i(en), .x_i(p_x), .y_i(p_y), .angle_o(pitch));
  ata_atan2_lane u_roll  (.clk_i(clk_i), .en_i(en), .x_i(r_x), .y_i(r_y), .angle_o(roll));
  ata_atan2_lane u_yaw   (.clk_i(clk_i), .en_i(en), .x_i(w_x), .y_i(w_y), .angle_o(yaw));

  assign m_axis_tdata = OutW'({yaw, roll, pitch});

  // Pitch uses a non-negative x argument, so it never leaves a quarter turn.
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pitch >= -16'sd9000 && pitch <= 16'sd9000))
    else $error("pitch outside a quarter turn");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (roll >= -16'sd18000 && roll <= 16'sd18000))
    else $error("roll outside half a turn");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (yaw >= -16'sd18000 && yaw <= 16'sd18000))
    else $error("yaw outside half a turn");

endmodule

`default_nettype wire
